>>> sv/mthd_pkg.sv
// Package for the modifier tap/hold detector.
// Holds the operation and event codes and the result struct; depends on nothing.
package mthd_pkg;

  typedef enum logic [1:0] {
    OP_MODS    = 2'd0,
    OP_TICK    = 2'd1,
    OP_KEY     = 2'd2,
    OP_DISABLE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    EV_NONE       = 2'd0,
    EV_TAP        = 2'd1,
    EV_HOLD_START = 2'd2,
    EV_HOLD_END   = 2'd3
  } event_e;

  localparam int unsigned MaskW  = 8;
  localparam int unsigned TicksW = 16;

  localparam logic [MaskW-1:0]  TargetMaskRst = 8'd1;
  localparam logic [TicksW-1:0] HoldTicksRst  = 16'd250;

  // Register indexes on the configuration port.
  localparam logic CfgTargetMask = 1'b0;
  localparam logic CfgHoldTicks  = 1'b1;

  typedef struct packed {
    event_e ev;
    logic   held;
  } mthd_result_t;

endpackage

>>> sv/modifier_tap_hold_detector.sv
// Top level of the modifier tap/hold detector: input register, decision core, output register.
// Depends on mthd_pkg and mthd_core.
//
// Channel  | Direction | Contents
// s_axis   | in        | tuser[1:0] opcode, tdata[7:0] modifier_mask
// m_axis   | out       | tdata[1:0] event_code, tdata[2] held_level
// cfg      | in        | index 0 target_mask, index 1 hold_ticks
//
// One transaction per cycle sustained while m_axis does not stall.
// The input register feeds the core, which updates its state and fills the output register
// in the same cycle. A stall on m_axis holds the output register and the input register
// behind it. Reset clears all flags, the timer and both valid bits; the config gets reset values.
module modifier_tap_hold_detector import mthd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] modifier_mask
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [1:0] event_code, [2] held_level, rest zero
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic [MaskW-1:0]  target_mask_q;
  logic [TicksW-1:0] hold_ticks_q;

  logic             in_valid_q;
  op_e              op_q;
  logic [MaskW-1:0] mods_q;

  logic         out_valid_q;
  mthd_result_t out_q;
  mthd_result_t res;

  logic out_free, fire, accept;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_mask_q <= TargetMaskRst;
      hold_ticks_q  <= HoldTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTargetMask: target_mask_q <= cfg_data_i[MaskW-1:0];
        CfgHoldTicks:  hold_ticks_q  <= cfg_data_i[TicksW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(s_axis_tuser_i);
      mods_q <= s_axis_tdata_i;
    end
  end

  mthd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .op_i          (op_q),
    .mods_i        (mods_q),
    .target_mask_i (target_mask_q),
    .hold_ticks_i  (hold_ticks_q),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_q.held, out_q.ev};

endmodule

>>> sv/mthd_core.sv
// Tap/hold decision state: press flags, ignore logic and the one-shot hold timer.
// Depends on mthd_pkg.
module mthd_core import mthd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  op_e               op_i,
  input  logic [MaskW-1:0]  mods_i,
  input  logic [MaskW-1:0]  target_mask_i,
  input  logic [TicksW-1:0] hold_ticks_i,
  output mthd_result_t      res_o
);

  logic              full_q, full_d;
  logic              part_q, part_d;
  logic              held_q, held_d;
  logic              ignore_q, ignore_d;
  logic              foreign_q, foreign_d;
  logic              run_q, run_d;
  logic [TicksW-1:0] count_q, count_d;
  event_e            ev;

  logic m_part, m_full, m_other;

  assign m_part  = (target_mask_i & mods_i) != '0;
  assign m_full  = (target_mask_i == mods_i);
  assign m_other = (mods_i & ~target_mask_i) != '0;

  always_comb begin
    full_d    = full_q;
    part_d    = part_q;
    held_d    = held_q;
    ignore_d  = ignore_q;
    foreign_d = foreign_q;
    run_d     = run_q;
    count_d   = count_q;
    ev        = EV_NONE;
    unique case (op_i)
      OP_MODS: begin
        if (!ignore_q && full_q && !held_q && !m_full && !m_other) begin
          ev = EV_TAP;
        end else if (full_q && held_q && !m_full) begin
          held_d = 1'b0;
          ev     = EV_HOLD_END;
        end
        if (!part_q && m_part) begin
          ignore_d = 1'b0;
          run_d    = 1'b1;
          count_d  = hold_ticks_i;
        end
        // A foreign modifier down with a target one marks this press as ignored.
        if (m_other && m_part) begin
          foreign_d = 1'b0;
          ignore_d  = 1'b1;
        end
        full_d = m_full;
        part_d = m_part;
      end
      OP_TICK: begin
        if (run_q) begin
          if (count_q > TicksW'(1)) begin
            count_d = count_q - TicksW'(1);
          end else begin
            count_d = '0;
            run_d   = 1'b0;
            if (full_q && !ignore_q) begin
              held_d = 1'b1;
              ev     = EV_HOLD_START;
            end
          end
        end
      end
      OP_KEY: begin
        if (full_q) begin
          ignore_d = 1'b1;
        end
      end
      OP_DISABLE: begin
        run_d    = 1'b0;
        count_d  = '0;
        full_d   = 1'b0;
        part_d   = 1'b0;
        ignore_d = 1'b0;
        held_d   = 1'b0;
        if (held_q) begin
          ev = EV_HOLD_END;
        end
      end
      default: ;
    endcase
  end

  assign res_o.ev   = ev;
  assign res_o.held = held_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q    <= 1'b0;
      part_q    <= 1'b0;
      held_q    <= 1'b0;
      ignore_q  <= 1'b0;
      foreign_q <= 1'b0;
      run_q     <= 1'b0;
      count_q   <= '0;
    end else if (fire_i) begin
      full_q    <= full_d;
      part_q    <= part_d;
      held_q    <= held_d;
      ignore_q  <= ignore_d;
      foreign_q <= foreign_d;
      run_q     <= run_d;
      count_q   <= count_d;
    end
  end

  a_hold_start_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.ev == EV_HOLD_START |=> held_q)
    else $error("held flag not set after hold start");

  a_hold_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.ev == EV_HOLD_END |=> !held_q)
    else $error("held flag still set after hold end");

  a_idle_timer_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_q |-> count_q == '0)
    else $error("stopped timer holds a nonzero count");

endmodule

>>> dv/modifier_tap_hold_detector_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for modifier_tap_hold_detector: a directed opening, then random
// press/tick/release traffic under several stall patterns, checked against a built-in predictor.
// Depends on mthd_pkg and the detector RTL.
module modifier_tap_hold_detector_tb;
  import mthd_pkg::*;

  localparam int unsigned LongStallCycles = 300;
  localparam int unsigned WatchdogLimit   = 3000;

  typedef struct packed {
    op_e        op;
    logic [7:0] mods;
  } key_evt_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;  // [7:0] modifier_mask
  logic [1:0]  s_axis_tuser_i = 2'b00;  // [1:0] opcode
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;          // [1:0] event_code, [2] held_level
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_data_i = 16'h0000;

  modifier_tap_hold_detector dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  key_evt_t     key_events_q[$];
  mthd_result_t expected_events_q[$];

  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned stall_reqs = 0;
  int unsigned stall_served = 0;
  int unsigned stall_left = 0;
  logic        in_taken = 1'b0;

  // Register values as last written by the stimulus.
  logic [7:0]  target_set = TargetMaskRst;
  logic [15:0] hold_set = HoldTicksRst;

  // Predicted detector state.
  logic [7:0]  pred_target;
  logic [15:0] pred_hold;
  logic        st_full, st_part, st_held, st_ignore, st_foreign, st_tmr_on;
  logic [15:0] st_tmr;

  function automatic mthd_result_t predict_event(input op_e op, input logic [7:0] mods);
    mthd_result_t r;
    logic part, full, other;
    r.ev  = EV_NONE;
    part  = |(pred_target & mods);
    full  = (pred_target == mods);
    other = |(mods & ~pred_target);
    case (op)
      OP_MODS: begin
        if (other && part) st_foreign = 1'b1;
        if (!st_ignore && st_full && !st_held && !full && !other) begin
          r.ev = EV_TAP;
        end else if (st_full && st_held && !full) begin
          st_held = 1'b0;
          r.ev = EV_HOLD_END;
        end
        // First target key down (re)loads the one-shot timer.
        if (!st_part && part) begin
          st_ignore = 1'b0;
          st_tmr_on = 1'b1;
          st_tmr    = pred_hold;
        end
        if (st_foreign && other && part) begin
          st_foreign = 1'b0;
          st_ignore  = 1'b1;
        end
        st_full = full;
        st_part = part;
      end
      OP_TICK: begin
        if (st_tmr_on) begin
          if (st_tmr > 16'd1) begin
            st_tmr = st_tmr - 16'd1;
          end else begin
            st_tmr    = 16'd0;
            st_tmr_on = 1'b0;
            if (st_full && !st_ignore) begin
              st_held = 1'b1;
              r.ev = EV_HOLD_START;
            end
          end
        end
      end
      OP_KEY: begin
        if (st_full) st_ignore = 1'b1;
      end
      default: begin
        st_tmr_on = 1'b0;
        st_tmr    = 16'd0;
        st_full   = 1'b0;
        st_part   = 1'b0;
        st_ignore = 1'b0;
        if (st_held) begin
          st_held = 1'b0;
          r.ev = EV_HOLD_END;
        end
      end
    endcase
    r.held = st_held;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  // Prediction, result checking and watchdog.
  always @(posedge clk_i) begin
    mthd_result_t want, got;
    logic in_acc, out_acc;
    in_acc  = s_axis_tvalid_i && s_axis_tready_o;
    out_acc = m_axis_tvalid_o && m_axis_tready_i;
    if (!rst_ni) begin
      pred_target = TargetMaskRst;
      pred_hold   = HoldTicksRst;
      {st_full, st_part, st_held, st_ignore, st_foreign, st_tmr_on} = '0;
      st_tmr      = 16'd0;
      in_taken   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgTargetMask) pred_target = cfg_data_i[7:0];
        else pred_hold = cfg_data_i;
      end
      in_taken <= in_acc;
      if (in_acc) begin
        expected_events_q.push_back(predict_event(op_e'(s_axis_tuser_i), s_axis_tdata_i));
        items_accepted++;
      end
      if (out_acc) begin
        got.ev   = event_e'(m_axis_tdata_o[1:0]);
        got.held = m_axis_tdata_o[2];
        if (expected_events_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result: event %s held %0b",
                                  got.ev.name(), got.held));
        end else begin
          want = expected_events_q.pop_front();
          if (want !== got) begin
            flag_mismatch($sformatf("expected event %s held %0b, got event %s held %0b",
                                    want.ev.name(), want.held, got.ev.name(), got.held));
          end
        end
      end
      if (in_acc || out_acc || cfg_we_i) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("modifier_tap_hold_detector_tb: FAIL");
        $finish;
      end
    end
  end

  // Input driver: a transaction stays on the bus until it is taken.
  always @(negedge clk_i) begin
    key_evt_t nxt;
    if (!s_axis_tvalid_i || in_taken) begin
      if (rst_ni && key_events_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = key_events_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tuser_i  <= nxt.op;
        s_axis_tdata_i  <= nxt.mods;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Result receiver with random stalls and an occasional long hold-off.
  always @(negedge clk_i) begin
    if (stall_reqs != stall_served) begin
      stall_served    <= stall_reqs;
      stall_left      <= LongStallCycles;
      m_axis_tready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left      <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_event(input op_e op, input logic [7:0] mods);
    key_evt_t e;
    e.op   = op;
    e.mods = mods;
    key_events_q.push_back(e);
    items_queued++;
  endtask

  // Returns once every queued transaction was taken and every result has come back.
  task automatic drain();
    do begin
      @(posedge clk_i);
      #1;
    end while (items_accepted != items_queued || expected_events_q.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    if (idx == CfgTargetMask) target_set = val[7:0];
    else hold_set = val;
  endtask

  // A realistic press: optional partial press, full combo, maybe a foreign modifier,
  // some ticks with stray key presses, then a release or a disable.
  task automatic queue_press_cycle();
    logic [7:0] t, part_mask, extra;
    int unsigned n_ticks;
    t = target_set;
    part_mask = t & 8'($urandom);
    if ($urandom_range(2) == 0 && part_mask != 8'h00) queue_event(OP_MODS, part_mask);
    queue_event(OP_MODS, t);
    extra = 8'($urandom) & ~t;
    if ($urandom_range(3) == 0 && extra != 8'h00) begin
      queue_event(OP_MODS, t | extra);
      if ($urandom_range(1) == 0) queue_event(OP_MODS, t);
    end
    n_ticks = (hold_set <= 16'd16) ? $urandom_range(hold_set + 2) : $urandom_range(20);
    for (int i = 0; i < n_ticks; i++) begin
      if ($urandom_range(7) == 0) queue_event(OP_KEY, 8'($urandom));
      queue_event(OP_TICK, 8'($urandom));
    end
    if ($urandom_range(7) == 0) begin
      queue_event(OP_DISABLE, 8'($urandom));
    end else begin
      if ($urandom_range(2) == 0) queue_event(OP_MODS, t & 8'($urandom));
      queue_event(OP_MODS, 8'h00);
    end
  endtask

  task automatic queue_random_traffic(input int unsigned n);
    int unsigned start;
    start = items_queued;
    while (items_queued - start < n) begin
      if ($urandom_range(3) != 0) begin
        queue_press_cycle();
      end else begin
        repeat ($urandom_range(4, 1)) queue_event(op_e'($urandom_range(3)), 8'($urandom));
      end
    end
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input logic [7:0] tgt, input logic [15:0] hold,
                           input int unsigned n, input bit long_stall);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    write_reg(CfgTargetMask, {8'h00, tgt});
    write_reg(CfgHoldTicks, hold);
    if (long_stall) stall_reqs++;
    queue_random_traffic(n);
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: tap, timer reload while running, ignored press, idle tick.
    queue_event(OP_MODS, 8'h01);
    queue_event(OP_MODS, 8'h00);
    queue_event(OP_MODS, 8'h01);
    queue_event(OP_MODS, 8'h03);
    queue_event(OP_MODS, 8'h01);
    queue_event(OP_MODS, 8'h00);
    queue_event(OP_TICK, 8'hFF);
    queue_event(OP_KEY, 8'h00);
    queue_event(OP_DISABLE, 8'hAA);
    queue_event(OP_TICK, 8'h55);
    queue_event(OP_MODS, 8'hFF);
    queue_event(OP_MODS, 8'h00);
    drain();

    // Hold start, hold end by release, a disable with nothing held, then a second hold start.
    write_reg(CfgTargetMask, 16'h0081);
    write_reg(CfgHoldTicks, 16'd1);
    queue_event(OP_MODS, 8'h81);
    queue_event(OP_TICK, 8'h00);
    queue_event(OP_TICK, 8'h00);
    queue_event(OP_MODS, 8'h80);
    queue_event(OP_MODS, 8'h81);
    queue_event(OP_TICK, 8'h00);
    queue_event(OP_DISABLE, 8'h00);
    queue_event(OP_MODS, 8'h81);
    queue_event(OP_TICK, 8'h00);
    drain();

    // Empty target mask keeps the held flag; retargeting lets the timer expire again
    // while held. A zero hold count expires on the first tick.
    write_reg(CfgTargetMask, 16'h0000);
    write_reg(CfgHoldTicks, 16'd0);
    queue_event(OP_MODS, 8'h00);
    queue_event(OP_TICK, 8'h00);
    drain();
    write_reg(CfgTargetMask, 16'h0081);
    queue_event(OP_MODS, 8'h81);
    queue_event(OP_TICK, 8'h00);
    queue_event(OP_MODS, 8'h00);
    drain();

    run_phase(0, 0, 8'hFF, 16'd1, 180, 1'b0);
    run_phase(77, 0, 8'($urandom_range(254, 1)), 16'($urandom_range(5, 2)), 180, 1'b0);
    run_phase(0, 77, 8'($urandom_range(254, 1)), 16'd4, 180, 1'b0);
    run_phase(26, 26, 8'h00, 16'd2, 100, 1'b0);
    run_phase(26, 26, 8'($urandom_range(254, 1)), 16'hFFFF, 100, 1'b0);
    run_phase(0, 0, 8'h81, 16'd2, 200, 1'b1);
    run_phase(26, 26, 8'($urandom_range(254, 1)), 16'($urandom_range(6, 1)), 150, 1'b0);

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("modifier_tap_hold_detector_tb: PASS");
    end else begin
      $display("modifier_tap_hold_detector_tb: FAIL");
    end
    $finish;
  end

endmodule
